// ----- hdl/awbd_pkg.sv -----
// awbd_pkg: shared types, constants and register indexes for the box downsampler
// no dependencies
package awbd_pkg;

    localparam int DefMaxWidth  = 8192;
    localparam int DefMaxHeight = 8192;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 14;
    localparam logic [CfgIdxW-1:0] CFG_ALPHA_MODE   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SCALE_SHIFT  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam int SumW  = 20;
    localparam int ASumW = 12;

    // one finished block handed from accumulation to the divide unit
    typedef struct packed {
        logic             alpha_mode;
        logic [4:0]       count;
        logic [SumW-1:0]  sum_r;
        logic [SumW-1:0]  sum_g;
        logic [SumW-1:0]  sum_b;
        logic [ASumW-1:0] sum_a;
        logic             last;
    } t_block;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_pix;

endpackage

// ----- hdl/awbd_ram.sv -----
// awbd_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module awbd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- hdl/awbd_front.sv -----
// awbd_front: raster position tracking and per-column accumulation in the line store
// depends on awbd_pkg, awbd_ram
module awbd_front
    import awbd_pkg::*;
#(
    parameter int MaxWidth  = DefMaxWidth,
    parameter int MaxHeight = DefMaxHeight
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_restart,
    input  logic                i_alpha_mode,
    input  logic [1:0]          i_scale_shift,
    input  logic [CfgDataW-1:0] i_image_width,
    input  logic [CfgDataW-1:0] i_image_height,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic [7:0]          i_alpha,
    output logic                o_blk_valid,
    output t_block              o_blk,
    input  logic                i_q_free
);
    localparam int Depth = MaxWidth / 2;
    localparam int AddrW = $clog2(Depth);
    localparam int PosW  = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight) + 1;
    localparam int WordW = 3 * SumW + ASumW;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_ADD} t_state;

    t_state r_state;
    logic [PosW-1:0] r_col, r_row;
    logic [PosW-1:0] r_bx, r_by;
    logic [2:0] r_cx, r_cy;
    logic r_in_range, r_fresh, r_end, r_last;
    logic [7:0] r_r, r_g, r_b, r_a;
    logic r_a_mode;
    logic r_blk_valid;
    t_block r_blk;

    // effective geometry
    logic [1:0] sh;
    logic [PosW-1:0] w, h;
    logic [2:0] bw, bh;
    logic [PosW-1:0] ow, oh;
    always_comb begin
        sh = (i_scale_shift == 2'd0) ? 2'd1 : (i_scale_shift == 2'd3 ? 2'd2 : i_scale_shift);
        w = (i_image_width == '0) ? PosW'(1)
          : ({1'b0, i_image_width} > 15'(MaxWidth) ? PosW'(MaxWidth) : PosW'(i_image_width));
        h = (i_image_height == '0) ? PosW'(1)
          : ({1'b0, i_image_height} > 15'(MaxHeight) ? PosW'(MaxHeight) : PosW'(i_image_height));
        if (w < (PosW'(1) << sh)) begin
            bw = w[2:0];
            ow = PosW'(1);
        end else begin
            bw = 3'(1 << sh);
            ow = w >> sh;
        end
        if (h < (PosW'(1) << sh)) begin
            bh = h[2:0];
            oh = PosW'(1);
        end else begin
            bh = 3'(1 << sh);
            oh = h >> sh;
        end
    end

    // line store: three colour lanes and alpha sum in one word
    logic we;
    logic [WordW-1:0] wdata, rdata;
    logic [AddrW-1:0] addr;
    assign addr = r_bx[AddrW-1:0];
    awbd_ram #(.Width(WordW), .Depth(Depth)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(addr), .i_wdata(wdata),
        .i_raddr(addr), .o_rdata(rdata)
    );

    // new sums
    logic [SumW-1:0] vr, vg, vb, br, bg, bb, nr, ng, nb;
    logic [ASumW-1:0] va, ba, na;
    always_comb begin
        vr = r_a_mode ? SumW'(r_r) * SumW'(r_a) : SumW'(r_r);
        vg = r_a_mode ? SumW'(r_g) * SumW'(r_a) : SumW'(r_g);
        vb = r_a_mode ? SumW'(r_b) * SumW'(r_a) : SumW'(r_b);
        va = r_a_mode ? ASumW'(r_a) : '0;
        {br, bg, bb, ba} = r_fresh ? '0 : rdata;
        nr = br + vr;
        ng = bg + vg;
        nb = bb + vb;
        na = ba + va;
        wdata = {nr, ng, nb, na};
        we = (r_state == S_ADD) && r_in_range;
    end

    assign o_ready = (r_state == S_IDLE) && i_q_free && !r_blk_valid;
    assign o_blk_valid = r_blk_valid;
    assign o_blk = r_blk;

    // sequencer, position counters and block classification
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col <= '0;
            r_row <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_cx <= '0;
            r_cy <= '0;
            r_blk_valid <= 1'b0;
        end else if (i_cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_cx <= '0;
            r_cy <= '0;
        end else begin
            r_blk_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_r <= i_red;
                        r_g <= i_green;
                        r_b <= i_blue;
                        r_a <= i_alpha;
                        r_a_mode <= i_alpha_mode;
                        r_in_range <= (r_bx < ow) && (r_by < oh);
                        r_fresh <= (r_cx == 3'd0) && (r_cy == 3'd0);
                        r_end <= (r_cx == bw - 3'd1) && (r_cy == bh - 3'd1);
                        r_last <= (r_bx == ow - PosW'(1)) && (r_by == oh - PosW'(1));
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_ADD;
                S_ADD: begin
                    if (r_in_range && r_end) begin
                        r_blk_valid <= 1'b1;
                        r_blk.alpha_mode <= r_a_mode;
                        r_blk.count <= 5'(bw * bh);
                        r_blk.sum_r <= nr;
                        r_blk.sum_g <= ng;
                        r_blk.sum_b <= nb;
                        r_blk.sum_a <= na;
                        r_blk.last <= r_last;
                    end
                    // advance the raster position
                    if (r_col + PosW'(1) >= w) begin
                        r_col <= '0;
                        r_bx <= '0;
                        r_cx <= '0;
                        if (r_row + PosW'(1) >= h) begin
                            r_row <= '0;
                            r_by <= '0;
                            r_cy <= '0;
                        end else begin
                            r_row <= r_row + PosW'(1);
                            if (r_cy == bh - 3'd1) begin
                                r_cy <= '0;
                                r_by <= r_by + PosW'(1);
                            end else begin
                                r_cy <= r_cy + 3'd1;
                            end
                        end
                    end else begin
                        r_col <= r_col + PosW'(1);
                        if (r_cx == bw - 3'd1) begin
                            r_cx <= '0;
                            r_bx <= r_bx + PosW'(1);
                        end else begin
                            r_cx <= r_cx + 3'd1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/awbd_queue.sv -----
// awbd_queue: two-entry queue of finished blocks between front and divide unit
// depends on awbd_pkg
module awbd_queue
    import awbd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_block i_data,
    output logic   o_free,
    output logic   o_valid,
    input  logic   i_pop,
    output t_block o_data
);
    t_block r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    // room kept for one block already in flight in the front
    assign o_free = (r_cnt == 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ----- hdl/awbd_back.sv -----
// awbd_back: restoring divider turning block sums into averaged output words
// depends on awbd_pkg
module awbd_back
    import awbd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_pop,
    input  t_block i_blk,
    output logic   o_valid,
    input  logic   i_ready,
    output t_pix   o_pix
);
    localparam int NumW = SumW + 1;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_OUT} t_state;

    t_state r_state;
    t_block r_blk;
    logic [1:0] r_ch;
    logic [4:0] r_bit;
    logic [NumW-1:0] r_num, r_rem;
    logic [ASumW-1:0] r_den;
    logic [NumW-1:0] r_q;
    logic [7:0] r_red, r_green, r_blue;
    t_pix r_pix;
    logic r_valid;

    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign o_valid = r_valid;
    assign o_pix = r_pix;

    // finished word moves to the output register once it is free
    logic out_load;
    assign out_load = (r_state == S_OUT) && (r_ch == 2'd3) && (!r_valid || i_ready);

    // numerator and divisor for the current channel
    logic [NumW-1:0] num;
    logic [ASumW-1:0] den;
    always_comb begin
        if (r_blk.alpha_mode && r_ch != 2'd3) begin
            den = r_blk.sum_a;
        end else begin
            den = ASumW'(r_blk.count);
        end
        case (r_ch)
            2'd0: num = NumW'(r_blk.sum_r);
            2'd1: num = NumW'(r_blk.sum_g);
            2'd2: num = NumW'(r_blk.sum_b);
            default: num = NumW'(r_blk.sum_a);
        endcase
        num = num + NumW'(den >> 1);
    end

    logic [NumW-1:0] trial;
    assign trial = {r_rem[NumW-2:0], r_num[NumW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_blk <= i_blk;
                        r_ch <= 2'd0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_num <= num;
                    r_den <= den;
                    r_rem <= '0;
                    r_q <= '0;
                    r_bit <= 5'(NumW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit a cycle
                    r_num <= r_num << 1;
                    if (trial >= NumW'(r_den)) begin
                        r_rem <= trial - NumW'(r_den);
                        r_q <= {r_q[NumW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_q <= {r_q[NumW-2:0], 1'b0};
                    end
                    if (r_bit == 5'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_bit <= r_bit - 5'd1;
                    end
                end
                S_OUT: begin
                    case (r_ch)
                        2'd0: r_red <= (r_den == '0) ? 8'd0 : r_q[7:0];
                        2'd1: r_green <= (r_den == '0) ? 8'd0 : r_q[7:0];
                        2'd2: r_blue <= (r_den == '0) ? 8'd0 : r_q[7:0];
                        default: ;
                    endcase
                    if (r_ch == 2'd3) begin
                        if (out_load) begin
                            r_pix.red <= r_red;
                            r_pix.green <= r_green;
                            r_pix.blue <= r_blue;
                            r_pix.alpha <= r_blk.alpha_mode ? r_q[7:0] : 8'd0;
                            r_pix.last <= r_blk.last;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_ch <= r_ch + 2'd1;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/alpha_weighted_box_downsample.sv -----
// channel   | valid     | ready     | payload
// pixel in  | i_valid   | o_ready   | i_red_in i_green_in i_blue_in i_alpha_in
// pixel out | o_valid   | i_ready   | o_red_out o_green_out o_blue_out o_alpha_out o_last_pixel
// config    | i_cfg_we  | (none)    | i_cfg_index i_cfg_data
// a source word goes through the front as line store read, then add and write back.
// a finished block is popped, then its four channels pass one after another through the shared bit-serial divider.
// synchronous active-low reset; the line store needs no clearing.
// the front stalls while the block queue holds a block; output stalls hold the divider.
// depends on awbd_pkg, awbd_front, awbd_queue, awbd_back
module alpha_weighted_box_downsample
    import awbd_pkg::*;
#(
    parameter int MaxWidth  = DefMaxWidth,
    parameter int MaxHeight = DefMaxHeight
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_red_in,
    input  logic [7:0]          i_green_in,
    input  logic [7:0]          i_blue_in,
    input  logic [7:0]          i_alpha_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_red_out,
    output logic [7:0]          o_green_out,
    output logic [7:0]          o_blue_out,
    output logic [7:0]          o_alpha_out,
    output logic                o_last_pixel
);
    logic r_alpha_mode;
    logic [1:0] r_scale_shift;
    logic [CfgDataW-1:0] r_image_width, r_image_height;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode <= 1'b1;
            r_scale_shift <= 2'd1;
            r_image_width <= CfgDataW'(1024);
            r_image_height <= CfgDataW'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA_MODE:   r_alpha_mode <= i_cfg_data[0];
                CFG_SCALE_SHIFT:  r_scale_shift <= i_cfg_data[1:0];
                CFG_IMAGE_WIDTH:  r_image_width <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic blk_valid, q_free, q_valid, q_pop;
    t_block blk, q_blk;
    t_pix pix;

    awbd_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_restart(i_cfg_we),
        .i_alpha_mode(r_alpha_mode), .i_scale_shift(r_scale_shift),
        .i_image_width(r_image_width), .i_image_height(r_image_height),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_red(i_red_in), .i_green(i_green_in), .i_blue(i_blue_in), .i_alpha(i_alpha_in),
        .o_blk_valid(blk_valid), .o_blk(blk), .i_q_free(q_free)
    );

    awbd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(blk_valid), .i_data(blk),
        .o_free(q_free), .o_valid(q_valid), .i_pop(q_pop), .o_data(q_blk)
    );

    awbd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_pop(q_pop),
        .i_blk(q_blk), .o_valid(o_valid), .i_ready(i_ready), .o_pix(pix)
    );

    assign o_red_out = pix.red;
    assign o_green_out = pix.green;
    assign o_blue_out = pix.blue;
    assign o_alpha_out = pix.alpha;
    assign o_last_pixel = pix.last;
endmodule

// ----- hdl/awbd_checker.sv -----
// awbd_checker: port-level checks on the box downsampler, bound to the top level
// depends on awbd_pkg
module awbd_checker
    import awbd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_alpha_out,
    input logic [7:0] o_red_out
);
    // a result held under stall keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red_out) && $stable(o_alpha_out))
        else $error("output changed under stall");

    // nothing accepted right after an accept: the front is still busy with the line store read and add
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted back to back");

    // no result right out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind alpha_weighted_box_downsample awbd_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_alpha_out(o_alpha_out),
    .o_red_out(o_red_out)
);
